// ===== src/assert_macros.svh =====
// Assertion macros shared by the framebuffer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (active low).
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== src/mpfd_pkg.sv =====
// Package for the monochrome page framebuffer: field widths and command codes.
// Depends on nothing; used by the channel interfaces and the top level.
package mpfd_pkg;

    typedef logic [2:0]        t_action;
    typedef logic [1:0]        t_color;
    typedef logic signed [10:0] t_pos;
    typedef logic [7:0]        t_size;
    typedef logic [9:0]        t_index;
    typedef logic [7:0]        t_byte;

    localparam t_action ACT_CLEAR = 3'd0;
    localparam t_action ACT_FILL  = 3'd1;
    localparam t_action ACT_PIXEL = 3'd2;
    localparam t_action ACT_HLINE = 3'd3;
    localparam t_action ACT_VLINE = 3'd4;
    localparam t_action ACT_RECT  = 3'd5;
    localparam t_action ACT_READ  = 3'd6;

    localparam t_color COL_WHITE  = 2'd0;
    localparam t_color COL_BLACK  = 2'd1;
    localparam t_color COL_INVERT = 2'd2;

    localparam t_byte BYTE_ONES = 8'hFF;

endpackage

// ===== src/mpfd_cmd_if.sv =====
// Command channel of the framebuffer: valid/ready plus one drawing command.
// Depends on mpfd_pkg for the field types.
interface mpfd_cmd_if;
    import mpfd_pkg::*;

    logic    valid;
    logic    ready;
    t_action action;
    t_pos    x;
    t_pos    y;
    t_pos    x_end;
    t_pos    y_end;
    t_size   width;
    t_size   height;
    t_color  color;
    t_index  byte_index;

    modport source (
        output valid, action, x, y, x_end, y_end, width, height, color, byte_index,
        input  ready
    );
    modport sink (
        input  valid, action, x, y, x_end, y_end, width, height, color, byte_index,
        output ready
    );
endinterface

// ===== src/mpfd_rsp_if.sv =====
// Response channel of the framebuffer: valid/ready plus the read byte.
// Depends on mpfd_pkg for the field types.
interface mpfd_rsp_if;
    import mpfd_pkg::*;

    logic  valid;
    logic  ready;
    t_byte read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

// ===== src/mpfd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module mpfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/monochrome_page_framebuffer_draw.sv =====
// Top level of the monochrome page framebuffer with drawing commands.
// Depends on mpfd_pkg, mpfd_cmd_if, mpfd_rsp_if, mpfd_ram and assert_macros.svh.
//
// The block holds a DISPLAY_WIDTH x DISPLAY_HEIGHT 1-bit image in page layout
// (byte page*DISPLAY_WIDTH+column holds eight rows, lowest row in bit 0) and
// takes one command at a time; every command returns exactly one response
// beat, which carries the byte for a read and zero otherwise. Drawing walks
// the clipped area byte by byte through one read-modify-write path on the
// store RAM, one byte per cycle, after the clip, prep and start states that
// set up a pixel, line or rectangle. Clear and fill write every byte. After
// reset the store is zeroed by a pass over all STORE_BYTES bytes (1024 at
// the default size) during which no command is accepted; the rotate register
// may be written at any time the block is idle and defaults to 1.
`include "assert_macros.svh"

module monochrome_page_framebuffer_draw #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mpfd_cmd_if.sink   i_cmd,
    mpfd_rsp_if.source o_rsp,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata
);
    import mpfd_pkg::*;

    localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int AW = $clog2(STORE_BYTES);
    localparam int CW = $clog2(DISPLAY_WIDTH);
    localparam int RW = $clog2(DISPLAY_HEIGHT) + 1;
    localparam int PW = RW - 3;

    localparam logic signed [12:0] XMAX = 13'(DISPLAY_WIDTH - 1);
    localparam logic signed [12:0] YMAX = 13'(DISPLAY_HEIGHT - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(DISPLAY_WIDTH - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(DISPLAY_HEIGHT - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(STORE_BYTES - 1);
    localparam logic [12:0] STORE_SIZE = 13'(STORE_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_CLIP, S_PREP, S_START, S_WALK, S_DRAIN,
        S_SWEEP, S_READ, S_RD_WAIT, S_DONE
    } t_state;

    t_state r_state;

    logic          r_rotate;
    logic          r_init;
    t_byte         r_fill;
    logic [AW-1:0] r_sweep;

    t_color        r_color;
    t_index        r_index;
    t_byte         r_result;
    logic          r_out_valid;
    t_byte         r_out_data;

    logic signed [12:0] r_x0, r_x1, r_y0, r_y1;
    logic [CW-1:0] r_cx0, r_cx1, r_col_lo, r_col_hi, r_col;
    logic [RW-1:0] r_cy0, r_cy1, r_row_lo, r_row_hi;
    logic [PW-1:0] r_page, r_page_hi;
    logic [AW-1:0] r_addr, r_step;

    logic          r_wr_vld;
    logic [AW-1:0] r_wr_addr;
    t_byte         r_wr_mask;

    // Combinational helpers.
    logic signed [12:0] ext_x, ext_y, ext_xe, ext_ye, ext_w, ext_h;
    logic signed [12:0] clip_x0, clip_x1, clip_y0, clip_y1;
    logic          clip_empty;
    logic [2:0]    lo_bit, hi_bit;
    t_byte         walk_mask;
    logic [12:0]   idx_ext;
    logic          color_ok;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_byte         ram_wdata;
    logic [AW-1:0] ram_raddr;
    t_byte         ram_rdata;
    t_byte         mod_data;

    assign ext_x  = {{2{i_cmd.x[10]}}, i_cmd.x};
    assign ext_y  = {{2{i_cmd.y[10]}}, i_cmd.y};
    assign ext_xe = {{2{i_cmd.x_end[10]}}, i_cmd.x_end};
    assign ext_ye = {{2{i_cmd.y_end[10]}}, i_cmd.y_end};
    assign ext_w  = {5'd0, i_cmd.width};
    assign ext_h  = {5'd0, i_cmd.height};
    assign color_ok = (i_cmd.color == COL_WHITE) || (i_cmd.color == COL_BLACK)
                   || (i_cmd.color == COL_INVERT);

    assign clip_x0 = (r_x0 < 13'sd0) ? 13'sd0 : r_x0;
    assign clip_y0 = (r_y0 < 13'sd0) ? 13'sd0 : r_y0;
    assign clip_x1 = (r_x1 > XMAX) ? XMAX : r_x1;
    assign clip_y1 = (r_y1 > YMAX) ? YMAX : r_y1;
    assign clip_empty = (clip_x1 < clip_x0) || (clip_y1 < clip_y0);

    // Rows of the current page that fall inside the span; only the first and
    // last page of the span are partial.
    assign lo_bit = (r_page == r_row_lo[RW-1:3]) ? r_row_lo[2:0] : 3'd0;
    assign hi_bit = (r_page == r_page_hi) ? r_row_hi[2:0] : 3'd7;
    assign walk_mask = (BYTE_ONES << lo_bit) & (BYTE_ONES >> (3'd7 - hi_bit));

    assign idx_ext = {3'd0, r_index};

    always_comb begin
        unique case (r_color)
            COL_WHITE:  mod_data = ram_rdata | r_wr_mask;
            COL_BLACK:  mod_data = ram_rdata & ~r_wr_mask;
            COL_INVERT: mod_data = ram_rdata ^ r_wr_mask;
            default:    mod_data = ram_rdata;
        endcase
    end

    always_comb begin
        if (r_state == S_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep;
            ram_wdata = r_fill;
        end else begin
            ram_we    = r_wr_vld;
            ram_waddr = r_wr_addr;
            ram_wdata = mod_data;
        end
    end

    assign ram_raddr = (r_state == S_READ) ? idx_ext[AW-1:0] : r_addr;

    mpfd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_init      <= 1'b1;
            r_fill      <= '0;
            r_sweep     <= '0;
            r_rotate    <= 1'b1;
            r_out_valid <= 1'b0;
            r_wr_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rotate <= i_cfg_wdata;
            end
            // The completion state owns the response register while it runs.
            if (o_rsp.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            // Each walk read is written back in the cycle after it.
            r_wr_vld <= (r_state == S_WALK);

            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_color  <= i_cmd.color;
                        r_index  <= i_cmd.byte_index;
                        r_result <= '0;
                        r_x0     <= ext_x;
                        r_y0     <= ext_y;
                        r_sweep  <= '0;
                        unique case (i_cmd.action)
                            ACT_CLEAR: begin
                                r_fill  <= '0;
                                r_state <= S_SWEEP;
                            end
                            ACT_FILL: begin
                                r_fill  <= BYTE_ONES;
                                r_state <= S_SWEEP;
                            end
                            ACT_PIXEL: begin
                                r_x1    <= ext_x;
                                r_y1    <= ext_y;
                                r_state <= color_ok ? S_CLIP : S_DONE;
                            end
                            ACT_HLINE: begin
                                r_x1    <= ext_xe;
                                r_y1    <= ext_y;
                                r_state <= color_ok ? S_CLIP : S_DONE;
                            end
                            ACT_VLINE: begin
                                r_x1    <= ext_x;
                                r_y1    <= ext_ye;
                                r_state <= color_ok ? S_CLIP : S_DONE;
                            end
                            ACT_RECT: begin
                                r_x1    <= ext_x + ext_w - 13'sd1;
                                r_y1    <= ext_y + ext_h - 13'sd1;
                                r_state <= color_ok ? S_CLIP : S_DONE;
                            end
                            ACT_READ: begin
                                r_state <= S_READ;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                S_CLIP: begin
                    r_cx0 <= clip_x0[CW-1:0];
                    r_cx1 <= clip_x1[CW-1:0];
                    r_cy0 <= clip_y0[RW-1:0];
                    r_cy1 <= clip_y1[RW-1:0];
                    r_state <= clip_empty ? S_DONE : S_PREP;
                end

                // Map the clipped area into store coordinates; a flip swaps ends.
                S_PREP: begin
                    if (r_rotate) begin
                        r_col_lo <= COL_LAST - r_cx1;
                        r_col_hi <= COL_LAST - r_cx0;
                        r_row_lo <= ROW_LAST - r_cy1;
                        r_row_hi <= ROW_LAST - r_cy0;
                    end else begin
                        r_col_lo <= r_cx0;
                        r_col_hi <= r_cx1;
                        r_row_lo <= r_cy0;
                        r_row_hi <= r_cy1;
                    end
                    r_state <= S_START;
                end

                S_START: begin
                    r_page    <= r_row_lo[RW-1:3];
                    r_page_hi <= r_row_hi[RW-1:3];
                    r_col     <= r_col_lo;
                    r_addr    <= AW'(32'(r_row_lo[RW-1:3]) * DISPLAY_WIDTH
                                     + 32'(r_col_lo));
                    r_step    <= AW'(DISPLAY_WIDTH - 32'(r_col_hi - r_col_lo));
                    r_state   <= S_WALK;
                end

                // Read one byte per cycle; its write-back follows in the next cycle.
                S_WALK: begin
                    r_wr_addr <= r_addr;
                    r_wr_mask <= walk_mask;
                    if (r_col == r_col_hi) begin
                        if (r_page == r_page_hi) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_page <= r_page + PW'(1);
                            r_col  <= r_col_lo;
                            r_addr <= r_addr + r_step;
                        end
                    end else begin
                        r_col  <= r_col + CW'(1);
                        r_addr <= r_addr + AW'(1);
                    end
                end

                S_DRAIN: begin
                    r_state <= S_DONE;
                end

                S_SWEEP: begin
                    if (r_sweep == ADDR_LAST) begin
                        r_init  <= 1'b0;
                        r_state <= r_init ? S_IDLE : S_DONE;
                    end else begin
                        r_sweep <= r_sweep + AW'(1);
                    end
                end

                S_READ: begin
                    r_state <= (idx_ext < STORE_SIZE) ? S_RD_WAIT : S_DONE;
                end

                S_RD_WAIT: begin
                    r_result <= ram_rdata;
                    r_state  <= S_DONE;
                end

                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_result;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;

    `ASSERT_RST(a_wb_after_walk, i_clk, i_rst_n,
        r_wr_vld |-> ($past(r_state) == S_WALK), "write-back without a walk read")
    `ASSERT_RST(a_col_in_span, i_clk, i_rst_n,
        (r_state == S_WALK) |-> (r_col >= r_col_lo && r_col <= r_col_hi),
        "walk column left the span")
    `ASSERT_RST(a_addr_in_store, i_clk, i_rst_n,
        (r_state == S_WALK) |-> (r_addr <= ADDR_LAST), "walk address beyond store")
    `ASSERT_RST(a_rsp_from_done, i_clk, i_rst_n,
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE),
        "response beat raised outside command completion")

endmodule
